@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
// No dependencies; included by name from the checker source.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is active.
`define RTSC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define RTSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/rtsc_pkg.sv @@
// Package of the ratiometric temperature sensor chain: field widths,
// fixed constants, register indexes and controller/datapath handshake types.
// No dependencies.
package rtsc_pkg;

    localparam int BG_CODE_W   = 12;
    localparam int SENS_CODE_W = 12;
    localparam int WEIGHT_W    = 9;
    localparam int BGMV_W      = 11;
    localparam int MV_W        = 16;
    localparam int TEMP_W      = 10;
    localparam int ACC_W       = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;

    // Effective filter weight holds up to 2^12.
    localparam int PEFF_W      = 13;
    // Width of the filter's weighted sum before the final shift.
    localparam int FILT_W      = 28;
    localparam int VCLAMP_W    = 11;
    localparam int DIFF_MV_W   = 9;
    localparam int LIN_W       = 15;
    localparam int RECIP_W     = 30;

    localparam logic [WEIGHT_W-1:0]  WEIGHT_RESET = 9'd50;
    localparam logic [BGMV_W-1:0]    BGMV_RESET   = 11'd1212;
    localparam logic [BG_CODE_W-1:0] MIN_BG_CODE  = 12'd100;
    localparam logic [VCLAMP_W-1:0]  MV_HIGH      = 11'd1088;
    localparam logic [VCLAMP_W-1:0]  MV_LOW       = 11'd760;
    localparam logic [LIN_W-1:0]     SLOPE_NUM    = 15'd75;
    localparam logic [TEMP_W-1:0]    TEMP_OFFSET  = 10'd100;

    // floor(x / 41) == (x * 25576) >> 20 for every x up to 328 * 75.
    localparam logic [RECIP_W-1:0]   RECIP_41     = 30'd25576;
    localparam int                   RECIP_SHIFT  = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_WEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BANDGAP_MV    = 2'd1;

    typedef struct packed {
        logic load_in;
        logic div_step;
        logic sat;
        logic sens;
        logic lin;
        logic temp;
        logic filt;
        logic load_out;
    } rtsc_cmd_t;

    typedef struct packed {
        logic div_last;
    } rtsc_stat_t;

endpackage

@@ rtl/rtsc_ctrl.sv @@
// Sequencer of the temperature chain: steps the datapath through one item
// and owns the input ready and the output valid. Depends on rtsc_pkg.
module rtsc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output rtsc_pkg::rtsc_cmd_t cmd,
    input  rtsc_pkg::rtsc_stat_t stat
);
    import rtsc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_SAT, S_SENS, S_LIN, S_TEMP, S_FILT, S_LOAD
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = S_SAT;
                end
            end
            S_SAT: begin
                cmd.sat    = 1'b1;
                state_next = S_SENS;
            end
            S_SENS: begin
                cmd.sens   = 1'b1;
                state_next = S_LIN;
            end
            S_LIN: begin
                cmd.lin    = 1'b1;
                state_next = S_TEMP;
            end
            S_TEMP: begin
                cmd.temp   = 1'b1;
                state_next = S_FILT;
            end
            S_FILT: begin
                cmd.filt   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                // Hold the finished result until the output register frees up.
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ rtl/rtsc_datapath.sv @@
// Datapath of the temperature chain: configuration registers, restoring
// divider for the supply, scaling, linear map and low-pass filter.
// Depends on rtsc_pkg; driven by rtsc_ctrl.
module rtsc_datapath #(
    parameter int FILTER_SHIFT = 8,
    parameter int ADC_BITS     = 12
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    input  logic [rtsc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rtsc_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic [rtsc_pkg::BG_CODE_W-1:0]        s_bandgap_code,
    input  logic [rtsc_pkg::SENS_CODE_W-1:0]      s_sensor_code,
    input  rtsc_pkg::rtsc_cmd_t                   cmd,
    output rtsc_pkg::rtsc_stat_t                  stat,
    output logic [rtsc_pkg::MV_W-1:0]             m_supply_mv,
    output logic [rtsc_pkg::MV_W-1:0]             m_sensor_mv,
    output logic signed [rtsc_pkg::TEMP_W-1:0]    m_raw_temp,
    output logic signed [rtsc_pkg::TEMP_W-1:0]    m_filtered_temp
);
    import rtsc_pkg::*;

    localparam int NUM_W   = ADC_BITS + BGMV_W;
    localparam int CNT_W   = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);
    localparam int SPROD_W = SENS_CODE_W + MV_W;
    localparam logic [PEFF_W-1:0] UNIT = PEFF_W'(1) << FILTER_SHIFT;

    // Configuration.
    logic [WEIGHT_W-1:0]    weight_reg;
    logic [BGMV_W-1:0]      bgmv_reg;

    // Divider.
    logic [NUM_W-1:0]       quo_reg, quo_next;
    logic [BG_CODE_W-1:0]   rem_reg, rem_next;
    logic [BG_CODE_W-1:0]   div_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [BG_CODE_W:0]     rem_sh;
    logic [BG_CODE_W+1:0]   trial;
    logic [NUM_W-1:0]       numerator;

    // Following stages.
    logic [SENS_CODE_W-1:0] sc_reg;
    logic [MV_W-1:0]        supply_reg;
    logic [MV_W-1:0]        smv_reg;
    logic [LIN_W-1:0]       lin_reg;
    logic [TEMP_W-1:0]      raw_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    logic [SPROD_W-1:0]     sprod, sshift;
    logic [VCLAMP_W-1:0]    vclamp;
    logic [DIFF_MV_W-1:0]   dmv;
    logic [RECIP_W-1:0]     tprod;
    logic [TEMP_W-1:0]      quot41;
    logic [PEFF_W-1:0]      p_eff;
    logic signed [ACC_W:0]  diff;
    logic signed [PEFF_W+ACC_W+1:0] fprod;
    logic signed [FILT_W-1:0] fsum;

    // (2^ADC_BITS - 1) * bgmv as a shift and a subtract.
    assign numerator = (NUM_W'(bgmv_reg) << ADC_BITS) - NUM_W'(bgmv_reg);

    always_comb begin
        rem_sh = {rem_reg, quo_reg[NUM_W-1]};
        trial  = {1'b0, rem_sh} - {2'b00, div_reg};
        if (!trial[BG_CODE_W+1]) begin
            rem_next = trial[BG_CODE_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], 1'b1};
        end else begin
            rem_next = rem_sh[BG_CODE_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], 1'b0};
        end
    end

    assign stat.div_last = (cnt_reg == CNT_LAST);

    assign sprod  = SPROD_W'(sc_reg) * SPROD_W'(supply_reg);
    assign sshift = sprod >> ADC_BITS;

    always_comb begin
        if (smv_reg > MV_W'(MV_HIGH)) begin
            vclamp = MV_HIGH;
        end else if (smv_reg < MV_W'(MV_LOW)) begin
            vclamp = MV_LOW;
        end else begin
            vclamp = smv_reg[VCLAMP_W-1:0];
        end
    end
    assign dmv = DIFF_MV_W'(MV_HIGH - vclamp);

    assign tprod  = RECIP_W'(lin_reg) * RECIP_41;
    assign quot41 = tprod[RECIP_SHIFT+TEMP_W-1:RECIP_SHIFT];

    // Filter written as a + p * (x - a) / 2^N, which equals the weighted sum.
    assign p_eff = (PEFF_W'(weight_reg) > UNIT) ? UNIT : PEFF_W'(weight_reg);
    assign diff  = (ACC_W+1)'($signed(raw_reg)) - (ACC_W+1)'(acc_reg);
    assign fprod = $signed({1'b0, p_eff}) * diff;
    assign fsum  = (FILT_W'(acc_reg) <<< FILTER_SHIFT) + FILT_W'(fprod);
    assign acc_next = ACC_W'(fsum >>> FILTER_SHIFT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= WEIGHT_RESET;
            bgmv_reg   <= BGMV_RESET;
            acc_reg    <= '0;
            cnt_reg    <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_FILTER_WEIGHT: weight_reg <= cfg_data[WEIGHT_W-1:0];
                    CFG_BANDGAP_MV:    bgmv_reg   <= cfg_data[BGMV_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.load_in) begin
                cnt_reg <= '0;
            end else if (cmd.div_step) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.filt) begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            quo_reg <= numerator;
            rem_reg <= '0;
            div_reg <= (s_bandgap_code < MIN_BG_CODE) ? MIN_BG_CODE : s_bandgap_code;
            sc_reg  <= s_sensor_code;
        end else if (cmd.div_step) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (cmd.sat) begin
            supply_reg <= (|quo_reg[NUM_W-1:MV_W]) ? '1 : quo_reg[MV_W-1:0];
        end
        if (cmd.sens) begin
            smv_reg <= (|sshift[SPROD_W-1:MV_W]) ? '1 : sshift[MV_W-1:0];
        end
        if (cmd.lin) begin
            lin_reg <= LIN_W'(dmv) * SLOPE_NUM;
        end
        if (cmd.temp) begin
            raw_reg <= quot41 - TEMP_OFFSET;
        end
        if (cmd.load_out) begin
            m_supply_mv     <= supply_reg;
            m_sensor_mv     <= smv_reg;
            m_raw_temp      <= $signed(raw_reg);
            m_filtered_temp <= acc_reg[TEMP_W-1:0];
        end
    end

endmodule

@@ rtl/ratiometric_temp_sensor_chain_top.sv @@
// Top level of the ratiometric temperature sensor chain.
// Depends on rtsc_pkg, rtsc_ctrl and rtsc_datapath.
//
// Usage:
//   Input channel (s_valid/s_ready) takes one bandgap code and one sensor
//   code per transfer. Result channel (m_valid/m_ready) returns the supply
//   and sensor millivolts, the raw temperature and the filtered temperature
//   in tenths of a degree, one result per input.
//   Configuration channel (cfg_valid/cfg_ready, always ready) writes the
//   filter weight (index 0) or the bandgap millivolts (index 1); other
//   indexes are dropped. Write it only while the block is idle.
//   The supply division runs through a restoring divider at one quotient
//   bit per cycle, followed by six steps: saturation, sensor scaling,
//   linear map, temperature offset, filter and output load. A new item
//   is taken only once the previous one is in the output register.
//   s_ready is high only while no item is in work; a finished result sits
//   in the output register, and the next item may be taken meanwhile.
//   If the receiver stalls, the following result waits in the datapath
//   and no further input is taken until the output register frees up.
//   Reset (aresetn low, synchronous) clears the filter state to zero and
//   restores the weight to 50 and the bandgap voltage to 1212 mV.
module ratiometric_temp_sensor_chain_top #(
    parameter int FILTER_SHIFT = 8,
    parameter int ADC_BITS     = 12
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rtsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rtsc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [rtsc_pkg::BG_CODE_W-1:0]     s_bandgap_code,
    input  logic [rtsc_pkg::SENS_CODE_W-1:0]   s_sensor_code,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [rtsc_pkg::MV_W-1:0]          m_supply_mv,
    output logic [rtsc_pkg::MV_W-1:0]          m_sensor_mv,
    output logic signed [rtsc_pkg::TEMP_W-1:0] m_raw_temp,
    output logic signed [rtsc_pkg::TEMP_W-1:0] m_filtered_temp
);
    import rtsc_pkg::*;

    rtsc_cmd_t  cmd;
    rtsc_stat_t stat;

    assign cfg_ready = 1'b1;

    rtsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    rtsc_datapath #(
        .FILTER_SHIFT (FILTER_SHIFT),
        .ADC_BITS     (ADC_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_bandgap_code  (s_bandgap_code),
        .s_sensor_code   (s_sensor_code),
        .cmd             (cmd),
        .stat            (stat),
        .m_supply_mv     (m_supply_mv),
        .m_sensor_mv     (m_sensor_mv),
        .m_raw_temp      (m_raw_temp),
        .m_filtered_temp (m_filtered_temp)
    );

endmodule

@@ rtl/rtsc_checker.sv @@
// Port-level checks of the temperature chain and their binding to the top.
// Depends on rtsc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rtsc_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [rtsc_pkg::TEMP_W-1:0] m_raw_temp,
    input logic signed [rtsc_pkg::TEMP_W-1:0] m_filtered_temp
);
    import rtsc_pkg::*;

    // A result on offer stays until the receiver takes it.
    `RTSC_ASSERT(a_hold_valid, aclk, aresetn, m_valid && !m_ready |=> m_valid, "m_valid dropped")

    // One item at a time: taking an input closes the input side.
    `RTSC_ASSERT(a_one_item, aclk, aresetn, s_valid && s_ready |=> !s_ready, "second item taken")

    // Temperatures always lie within the mapped range.
    `RTSC_ASSERT(a_raw_range, aclk, aresetn, m_valid |-> (m_raw_temp >= -10'sd100) && (m_raw_temp <= 10'sd500), "raw out of range")
    `RTSC_ASSERT(a_filt_range, aclk, aresetn, m_valid |-> (m_filtered_temp >= -10'sd100) && (m_filtered_temp <= 10'sd500), "filtered out of range")

    // Nothing is offered in the cycle after reset.
    `RTSC_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_valid, "valid after reset")

endmodule

bind ratiometric_temp_sensor_chain_top rtsc_checker u_rtsc_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_raw_temp      (m_raw_temp),
    .m_filtered_temp (m_filtered_temp)
);

@@ tb/ratiometric_temp_sensor_chain_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for ratiometric_temp_sensor_chain_top: directed and random
// conversion pairs under several register settings, scored against a behavioral predictor.
// Depends on rtsc_pkg and the RTL top level.
module ratiometric_temp_sensor_chain_top_tb;
    import rtsc_pkg::*;

    localparam int FILTER_SHIFT      = 8;
    localparam int ADC_BITS          = 12;
    localparam int LATENCY           = ADC_BITS + 17;
    localparam int SLOPE_DEN         = 41;
    localparam int CODE_MAX          = (1 << ADC_BITS) - 1;
    localparam int MV_MAX            = 65535;
    localparam int ITEMS_PER_SETTING = 74;
    localparam int NUM_DIRECTED      = 12;
    localparam int NUM_SETTINGS      = 7;

    // Indexes that the block must drop.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [MV_W-1:0]   supply_mv;
        logic [MV_W-1:0]   sensor_mv;
        logic [TEMP_W-1:0] raw_temp;
        logic [TEMP_W-1:0] filtered_temp;
    } temp_reading_t;

    class temp_chain_scoreboard;
        logic [WEIGHT_W-1:0] weight;
        logic [BGMV_W-1:0]   bandgap_mv;
        int                  filter_acc;
        temp_reading_t       pending_readings[$];
        int                  readings_checked;
        int                  mismatches;

        function new();
            weight           = WEIGHT_RESET;
            bandgap_mv       = BGMV_RESET;
            filter_acc       = 0;
            readings_checked = 0;
            mismatches       = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_FILTER_WEIGHT: weight = data[WEIGHT_W-1:0];
                CFG_BANDGAP_MV:    bandgap_mv = data[BGMV_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned supply_for(logic [BG_CODE_W-1:0] bg_code);
            longint unsigned full_scale;
            longint unsigned divisor;
            longint unsigned quotient;
            full_scale = CODE_MAX;
            divisor    = (bg_code < MIN_BG_CODE) ? MIN_BG_CODE : bg_code;
            quotient   = (full_scale * bandgap_mv) / divisor;
            return (quotient > MV_MAX) ? MV_MAX : quotient;
        endfunction

        // Works out the reading for one accepted sample and advances the filter.
        function void note_sample(logic [BG_CODE_W-1:0] bg_code,
                                  logic [SENS_CODE_W-1:0] sens_code);
            longint unsigned supply;
            longint unsigned sens;
            longint          p;
            longint          mix;
            int              v;
            int              raw;
            temp_reading_t   r;
            supply = supply_for(bg_code);
            sens   = (sens_code * supply) >> ADC_BITS;
            if (sens > MV_MAX) sens = MV_MAX;
            v = (sens > MV_HIGH) ? int'(MV_HIGH) : int'(sens);
            if (v < int'(MV_LOW)) v = int'(MV_LOW);
            raw = ((int'(MV_HIGH) - v) * int'(SLOPE_NUM)) / SLOPE_DEN - int'(TEMP_OFFSET);
            p = (weight > (1 << FILTER_SHIFT)) ? (1 << FILTER_SHIFT) : weight;
            mix = ((longint'(1) << FILTER_SHIFT) - p) * filter_acc + p * raw;
            // Arithmetic shift gives the floor for negative sums.
            filter_acc = int'(mix >>> FILTER_SHIFT);
            r.supply_mv     = supply[MV_W-1:0];
            r.sensor_mv     = sens[MV_W-1:0];
            r.raw_temp      = raw[TEMP_W-1:0];
            r.filtered_temp = filter_acc[TEMP_W-1:0];
            pending_readings.push_back(r);
        endfunction

        function void compare_field(string field, longint want, longint got);
            if (want != got) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_result(temp_reading_t got);
            temp_reading_t want;
            if (pending_readings.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d",
                         $time, got.supply_mv, got.sensor_mv,
                         $signed(got.raw_temp), $signed(got.filtered_temp));
                return;
            end
            want = pending_readings.pop_front();
            readings_checked++;
            compare_field("supply_mv", want.supply_mv, got.supply_mv);
            compare_field("sensor_mv", want.sensor_mv, got.sensor_mv);
            compare_field("raw_temp", $signed(want.raw_temp), $signed(got.raw_temp));
            compare_field("filtered_temp", $signed(want.filtered_temp),
                          $signed(got.filtered_temp));
        endfunction
    endclass

    logic                         aclk;
    logic                         aresetn;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index;
    logic [CFG_DATA_W-1:0]        cfg_data;
    logic                         s_valid;
    logic                         s_ready;
    logic [BG_CODE_W-1:0]         s_bandgap_code;
    logic [SENS_CODE_W-1:0]       s_sensor_code;
    logic                         m_valid;
    logic                         m_ready;
    logic [MV_W-1:0]              m_supply_mv;
    logic [MV_W-1:0]              m_sensor_mv;
    logic signed [TEMP_W-1:0]     m_raw_temp;
    logic signed [TEMP_W-1:0]     m_filtered_temp;

    temp_chain_scoreboard scoreboard = new();

    int  samples_sent = 0;
    int  cfg_writes   = 0;
    bit  tx_steady    = 1'b0;
    bit  rx_steady    = 1'b0;
    int  rx_hold      = 0;

    logic [BG_CODE_W-1:0]   directed_bg [NUM_DIRECTED];
    logic [SENS_CODE_W-1:0] directed_sc [NUM_DIRECTED];
    logic [CFG_DATA_W-1:0]  weight_plan [NUM_SETTINGS];
    logic [CFG_DATA_W-1:0]  bgmv_plan [NUM_SETTINGS];

    ratiometric_temp_sensor_chain_top #(
        .FILTER_SHIFT(FILTER_SHIFT),
        .ADC_BITS    (ADC_BITS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_bandgap_code (s_bandgap_code),
        .s_sensor_code  (s_sensor_code),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_supply_mv    (m_supply_mv),
        .m_sensor_mv    (m_sensor_mv),
        .m_raw_temp     (m_raw_temp),
        .m_filtered_temp(m_filtered_temp)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    task automatic send_sample(input logic [BG_CODE_W-1:0] bg,
                               input logic [SENS_CODE_W-1:0] sc);
        int gap;
        if (samples_sent % 16 == 0) tx_steady = ($urandom_range(0, 3) == 0);
        gap = tx_steady ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        = 1'b1;
        s_bandgap_code = bg;
        s_sensor_code  = sc;
        do @(posedge aclk); while (!s_ready);
        scoreboard.note_sample(bg, sc);
        samples_sent++;
        @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        scoreboard.write_reg(index, data);
        cfg_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Holds off the sender until every outstanding reading has come back.
    task automatic drain_results();
        s_valid = 1'b0;
        while (scoreboard.pending_readings.size() != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    // Most samples aim the sensor voltage near the 760..1088 mV window so the
    // linear map and the filter see interior values; the rest are edge codes
    // and plain noise.
    task automatic pick_random(output logic [BG_CODE_W-1:0] bg,
                               output logic [SENS_CODE_W-1:0] sc);
        int              kind;
        int              target_mv;
        longint unsigned supply;
        longint unsigned code;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            bg        = BG_CODE_W'($urandom_range(MIN_BG_CODE, CODE_MAX));
            supply    = scoreboard.supply_for(bg);
            target_mv = $urandom_range(700, 1150);
            if (supply == 0) begin
                code = $urandom_range(0, CODE_MAX);
            end else begin
                code = (longint'(target_mv) << ADC_BITS) / supply;
                if (code > CODE_MAX) code = CODE_MAX;
            end
            sc = code[SENS_CODE_W-1:0];
        end else if (kind < 85) begin
            bg = BG_CODE_W'($urandom_range(0, 127));
            sc = SENS_CODE_W'($urandom_range(0, CODE_MAX));
        end else begin
            bg = BG_CODE_W'($urandom_range(0, CODE_MAX));
            sc = SENS_CODE_W'($urandom_range(0, CODE_MAX));
        end
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = (rx_hold == 0);
            if (rx_hold > 0) rx_hold--;
        end
    end

    always @(posedge aclk) begin
        temp_reading_t seen;
        if (aresetn && m_valid && m_ready) begin
            seen.supply_mv     = m_supply_mv;
            seen.sensor_mv     = m_sensor_mv;
            seen.raw_temp      = m_raw_temp;
            seen.filtered_temp = m_filtered_temp;
            scoreboard.check_result(seen);
            if (scoreboard.readings_checked % 20 == 0) rx_steady = ($urandom_range(0, 3) == 0);
            rx_hold = rx_steady ? 0 : $urandom_range(0, 7);
        end
    end

    initial begin
        #2_000_000;
        $display("Run stopped: no finish within the time limit.");
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int                     i;
        int                     setting;
        logic [BG_CODE_W-1:0]   bg;
        logic [SENS_CODE_W-1:0] sc;

        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_bandgap_code = '0;
        s_sensor_code  = '0;

        // Zero and small bandgap codes, full-scale codes, and sensor codes that land
        // below, exactly on and above both clamp bounds at the reset bandgap voltage.
        directed_bg = '{12'd0, 12'd0, 12'd99, 12'd100, 12'd100, 12'd4095,
                        12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd1500, 12'd1500};
        directed_sc = '{12'd0, 12'd4095, 12'd2048, 12'd4095, 12'd0, 12'd4095,
                        12'd0, 12'd2569, 12'd3677, 12'd3676, 12'd600, 12'd1000};
        // Weight data with the upper bits set checks masking and the clamp to unity.
        weight_plan = '{11'd256, 11'd0, 11'h7FF, 11'd1, 11'h580, 11'd128, 11'd50};
        bgmv_plan   = '{11'd1400, 11'd1000, 11'd2047, 11'd0, 11'd1212, 11'd1100, 11'd1212};

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (i = 0; i < NUM_DIRECTED; i++) send_sample(directed_bg[i], directed_sc[i]);
        for (i = 0; i < ITEMS_PER_SETTING; i++) begin
            pick_random(bg, sc);
            send_sample(bg, sc);
        end
        drain_results();

        for (setting = 0; setting < NUM_SETTINGS; setting++) begin
            write_register(CFG_FILTER_WEIGHT, weight_plan[setting]);
            write_register(CFG_BANDGAP_MV, bgmv_plan[setting]);
            write_register((setting % 2 == 0) ? CFG_SPARE_A : CFG_SPARE_B,
                           CFG_DATA_W'($urandom_range(0, 2047)));
            // Smallest valid code at full sensor scale: overflows at high bandgap voltage.
            send_sample(MIN_BG_CODE, CODE_MAX);
            for (i = 0; i < ITEMS_PER_SETTING; i++) begin
                pick_random(bg, sc);
                send_sample(bg, sc);
            end
            drain_results();
        end

        $display("Checked %0d readings from %0d samples across %0d register settings (%0d writes).",
                 scoreboard.readings_checked, samples_sent, NUM_SETTINGS + 1, cfg_writes);
        $display("Weights ran from 0 through masked and clamped values; bandgap from 0 to 2047 mV.");
        if (scoreboard.mismatches == 0 && scoreboard.pending_readings.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/rtsc_pkg.sv
rtl/rtsc_ctrl.sv
rtl/rtsc_datapath.sv
rtl/ratiometric_temp_sensor_chain_top.sv
rtl/rtsc_checker.sv
tb/ratiometric_temp_sensor_chain_top_tb.sv
